// ----- rtl/prq_pkg.sv -----
// Package: command codes, request/result/slot types for the print request queue.
package prq_pkg;

    localparam int DEFAULT_DEPTH = 16;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] entry_id;
        logic        immediate;
        logic [5:0]  priority_req;
        logic [31:0] submit_date;
        logic        rank_valid;
        logic [15:0] rank;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [3:0]  position;
        logic [4:0]  entry_count;
        logic        head_valid;
        logic [31:0] head_id;
        logic        overflow;
    } rsp_t;

    typedef struct packed {
        logic        imm;
        logic [5:0]  pri;
        logic [31:0] date;
        logic        rank_valid;
        logic [15:0] rank;
    } key_t;

    typedef struct packed {
        logic        used;
        logic [31:0] id;
        key_t        key;
    } slot_t;

    typedef struct packed {
        cmd_t cmd;
        logic ins_en;
        logic rem_en;
    } cell_ctrl_t;

endpackage

// ----- rtl/print_request_priority_queue.sv -----
// Top level: ordered print request queue built from a chain of slot cells.
// A request is held in go_reg, then done_reg; slots and results update as done_reg is set.
// Busy is high for the cycle the cell chain updates; no new request is accepted while busy.
// A new request may be accepted in the cycle the previous result is strobed.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Reset clears the slot used bits, the entry count and control; ids and keys are not cleared.
module print_request_priority_queue #(
    parameter int QUEUE_DEPTH = prq_pkg::DEFAULT_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  prq_pkg::req_t request,
    output logic          busy,
    output logic          done,
    output prq_pkg::rsp_t result
);
    import prq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    req_t             req_reg;
    logic             go_reg;
    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             found_reg;
    logic             found_next;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic             ovf_reg;
    logic             ovf_next;

    cell_ctrl_t       ctrl;
    slot_t            new_slot;
    slot_t            slots [QUEUE_DEPTH];
    logic             ahead [QUEUE_DEPTH+1];
    logic [QUEUE_DEPTH-1:0] first;
    logic [QUEUE_DEPTH-1:0] used_vec;
    logic             full;
    logic             any_first;
    logic [IDX_W-1:0] pos_enc;

    assign full = count_reg == CNT_W'(QUEUE_DEPTH);

    assign new_slot = '{used: 1'b1, id: req_reg.entry_id,
                        key: '{imm: req_reg.immediate, pri: req_reg.priority_req,
                               date: req_reg.submit_date, rank_valid: req_reg.rank_valid,
                               rank: req_reg.rank}};

    always_comb
    begin
        ctrl.cmd    = cmd_t'(req_reg.command);
        ctrl.ins_en = go_reg && (ctrl.cmd == CMD_INSERT) && !full;
        ctrl.rem_en = go_reg && (ctrl.cmd == CMD_REMOVE);
    end

    assign ahead[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            slot_t left_s;
            slot_t right_s;
            if (g == 0)
            begin : g_head
                assign left_s = '0;
            end
            else
            begin : g_mid_l
                assign left_s = slots[g-1];
            end
            if (g == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_s = '0;
            end
            else
            begin : g_mid_r
                assign right_s = slots[g+1];
            end
            prq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_slot   (new_slot),
                .left       (left_s),
                .right      (right_s),
                .before_in  (ahead[g]),
                .before_out (ahead[g+1]),
                .first      (first[g]),
                .slot       (slots[g])
            );
            assign used_vec[g] = slots[g].used;
        end
    endgenerate

    always_comb
    begin
        pos_enc = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (first[i])
            begin
                pos_enc = pos_enc | IDX_W'(i);
            end
        end
    end

    assign any_first = |first;

    always_comb
    begin
        found_next = 1'b0;
        pos_next   = '0;
        ovf_next   = 1'b0;
        count_next = count_reg;
        unique case (ctrl.cmd) inside
            CMD_INSERT:
            begin
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    pos_next   = pos_enc;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE, CMD_FIND:
            begin
                found_next = any_first;
                pos_next   = any_first ? pos_enc : '0;
                if (ctrl.cmd == CMD_REMOVE && any_first)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                found_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg    <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            go_reg   <= start && !busy;
            done_reg <= go_reg;
            if (go_reg)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        if (go_reg)
        begin
            found_reg <= found_next;
            pos_reg   <= pos_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign busy = go_reg;
    assign done = done_reg;

    always_comb
    begin
        result.found       = found_reg;
        result.position    = 4'(pos_reg);
        result.entry_count = 5'(count_reg);
        result.head_valid  = count_reg != '0;
        result.head_id     = (count_reg != '0) ? slots[0].id : 32'd0;
        result.overflow    = ovf_reg;
    end

    a_done_follows_go: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(go_reg))
        else $error("result strobe without an executed request");

    a_go_done_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(go_reg && done_reg))
        else $error("execute and result cycles overlap");

    a_used_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_vec) == int'(count_reg))
        else $error("slot used bits disagree with entry count");

    a_overflow_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && ovf_reg) |-> (count_reg == CNT_W'(QUEUE_DEPTH)))
        else $error("overflow reported with free slots");

    a_found_not_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> (req_reg.command == CMD_REMOVE ||
                                     req_reg.command == CMD_FIND))
        else $error("found flagged for a non-search request");

endmodule

// ----- rtl/prq_cell.sv -----
// One queue slot: holds an entry, compares it to the request, shifts with its neighbors.
module prq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  prq_pkg::cell_ctrl_t ctrl,
    input  prq_pkg::slot_t     new_slot,
    input  prq_pkg::slot_t     left,
    input  prq_pkg::slot_t     right,
    input  logic               before_in,
    output logic               before_out,
    output logic               first,
    output prq_pkg::slot_t     slot
);
    import prq_pkg::*;

    logic        used_reg;
    logic        used_next;
    logic [31:0] id_reg;
    logic [31:0] id_next;
    key_t        key_reg;
    key_t        key_next;
    logic        hit;

    function automatic logic is_later(key_t a, logic [31:0] ia, key_t b, logic [31:0] ib);
        logic res;
        if (a.date != 32'd0 && b.date != 32'd0 && a.date != b.date)
        begin
            res = a.date > b.date;
        end
        else if (a.rank_valid && b.rank_valid && a.rank != b.rank)
        begin
            res = a.rank > b.rank;
        end
        else if (a.date != 32'd0 && b.date == 32'd0)
        begin
            res = 1'b0;
        end
        else if (b.date != 32'd0 && a.date == 32'd0)
        begin
            res = 1'b1;
        end
        else
        begin
            res = ia > ib;
        end
        return res;
    endfunction

    function automatic logic precedes(key_t n, logic [31:0] in_id, key_t h, logic [31:0] ih);
        logic res;
        if (n.imm && h.imm)
        begin
            res = !is_later(n, in_id, h, ih);
        end
        else if (n.imm)
        begin
            res = 1'b1;
        end
        else if (h.imm)
        begin
            res = 1'b0;
        end
        else if (n.pri == h.pri)
        begin
            res = !is_later(n, in_id, h, ih);
        end
        else
        begin
            res = n.pri < h.pri;
        end
        return res;
    endfunction

    // insert: first free slot or first entry the new one precedes; else id match
    always_comb
    begin
        if (ctrl.cmd == CMD_INSERT)
        begin
            hit = !used_reg || precedes(new_slot.key, new_slot.id, key_reg, id_reg);
        end
        else
        begin
            hit = used_reg && (id_reg == new_slot.id);
        end
    end

    assign first      = hit && !before_in;
    assign before_out = before_in || hit;

    always_comb
    begin
        used_next = used_reg;
        id_next   = id_reg;
        key_next  = key_reg;
        if (ctrl.ins_en)
        begin
            if (before_in)
            begin
                used_next = left.used;
                id_next   = left.id;
                key_next  = left.key;
            end
            else if (hit)
            begin
                used_next = 1'b1;
                id_next   = new_slot.id;
                key_next  = new_slot.key;
            end
        end
        else if (ctrl.rem_en && before_out)
        begin
            used_next = right.used;
            id_next   = right.id;
            key_next  = right.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        key_reg <= key_next;
    end

    assign slot = '{used: used_reg, id: id_reg, key: key_reg};

endmodule

// ----- sim/queue_order_checker.sv -----
`timescale 1ns / 100ps
// Checker for the print request queue: tracks queue order and compares each result.
module queue_order_checker #(
    parameter int DEPTH = prq_pkg::DEFAULT_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  prq_pkg::req_t request,
    input  logic          done,
    input  prq_pkg::rsp_t result,
    output int            mismatches,
    output int            outstanding
);
    import prq_pkg::*;

    logic [31:0] held_id [DEPTH];
    key_t        held_key [DEPTH];
    int          held_n;
    rsp_t        awaited_results [$];
    rsp_t        want;

    function automatic bit is_later(key_t a, logic [31:0] ia, key_t b, logic [31:0] ib);
        if (a.date != 0 && b.date != 0 && a.date != b.date)
            return a.date > b.date;
        if (a.rank_valid && b.rank_valid && a.rank != b.rank)
            return a.rank > b.rank;
        if (a.date != 0 && b.date == 0)
            return 1'b0;
        if (a.date == 0 && b.date != 0)
            return 1'b1;
        return ia > ib;
    endfunction

    function automatic bit goes_ahead(key_t n, logic [31:0] nid, key_t h, logic [31:0] hid);
        if (n.imm && h.imm)
            return !is_later(n, nid, h, hid);
        if (n.imm)
            return 1'b1;
        if (h.imm)
            return 1'b0;
        if (n.pri == h.pri)
            return !is_later(n, nid, h, hid);
        return n.pri < h.pri;
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t s;
        key_t k;
        int   p;
        int   i;
        s = '0;
        p = 0;
        if (r.command == CMD_INSERT) begin
            k = {r.immediate, r.priority_req, r.submit_date, r.rank_valid, r.rank};
            if (held_n >= DEPTH) begin
                s.overflow = 1'b1;
            end
            else begin
                p = held_n;
                for (i = 0; i < held_n; i++) begin
                    if (goes_ahead(k, r.entry_id, held_key[i], held_id[i])) begin
                        p = i;
                        break;
                    end
                end
                for (i = held_n; i > p; i--) begin
                    held_id[i]  = held_id[i-1];
                    held_key[i] = held_key[i-1];
                end
                held_id[p]  = r.entry_id;
                held_key[p] = k;
                held_n++;
                s.position = 4'(p);
            end
        end
        else if (r.command == CMD_REMOVE || r.command == CMD_FIND) begin
            for (i = 0; i < held_n; i++) begin
                if (held_id[i] == r.entry_id) begin
                    s.found = 1'b1;
                    p = i;
                    break;
                end
            end
            if (s.found) begin
                s.position = 4'(p);
                if (r.command == CMD_REMOVE) begin
                    for (i = p; i + 1 < held_n; i++) begin
                        held_id[i]  = held_id[i+1];
                        held_key[i] = held_key[i+1];
                    end
                    held_n--;
                end
            end
        end
        s.entry_count = 5'(held_n);
        s.head_valid  = (held_n > 0);
        s.head_id     = (held_n > 0) ? held_id[0] : '0;
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_n = 0;
            awaited_results.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else begin
            if (done) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: found=%0d pos=%0d cnt=%0d hv=%0d head=%h ovf=%0d",
                                 result.found, result.position, result.entry_count,
                                 result.head_valid, result.head_id, result.overflow);
                end
                else begin
                    want = awaited_results.pop_front();
                    if (result.found !== want.found || result.position !== want.position ||
                        result.entry_count !== want.entry_count ||
                        result.head_valid !== want.head_valid ||
                        result.head_id !== want.head_id || result.overflow !== want.overflow)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp found=%0d pos=%0d cnt=%0d hv=%0d head=%h ",
                                      "ovf=%0d / got found=%0d pos=%0d cnt=%0d hv=%0d head=%h ",
                                      "ovf=%0d"},
                                     want.found, want.position, want.entry_count,
                                     want.head_valid, want.head_id, want.overflow,
                                     result.found, result.position, result.entry_count,
                                     result.head_valid, result.head_id, result.overflow);
                    end
                end
            end
            if (start && !busy)
                awaited_results.push_back(apply_request(request));
            outstanding = awaited_results.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top: request stimulus for the print request queue and the final verdict.
module tb_top;
    import prq_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;
    int   mismatches;
    int   outstanding;

    print_request_priority_queue uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    queue_order_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic issue(input req_t r);
        @(negedge clk);
        start <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
    endtask

    task automatic pause(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return 32'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic req_t make_insert(logic [31:0] id, logic imm, logic [5:0] pri,
                                         logic [31:0] date, logic rv, logic [15:0] rank);
        req_t r;
        r.command      = CMD_INSERT;
        r.entry_id     = id;
        r.immediate    = imm;
        r.priority_req = pri;
        r.submit_date  = date;
        r.rank_valid   = rv;
        r.rank         = rank;
        return r;
    endfunction

    function automatic req_t make_lookup(cmd_t c, logic [31:0] id);
        req_t r;
        r = make_insert(id, 1'($urandom), 6'($urandom), $urandom, 1'($urandom),
                        16'($urandom));
        r.command = c;
        return r;
    endfunction

    function automatic req_t random_request(bit filling);
        req_t r;
        int   sel;
        r.entry_id  = pick_id();
        r.immediate = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 5))
            0:       r.priority_req = 6'd0;
            1:       r.priority_req = 6'd20;
            2:       r.priority_req = 6'd39;
            default: r.priority_req = 6'($urandom_range(0, 39));
        endcase
        case ($urandom_range(0, 4))
            0:       r.submit_date = 32'd0;
            1:       r.submit_date = 32'd1000;
            2:       r.submit_date = 32'hFFFF_FFFF;
            default: r.submit_date = $urandom;
        endcase
        r.rank_valid = 1'($urandom);
        r.rank       = ($urandom_range(0, 2) == 0) ? 16'd7 : 16'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < (filling ? 60 : 25))
            r.command = CMD_INSERT;
        else if (sel < (filling ? 78 : 70))
            r.command = CMD_REMOVE;
        else if (sel < 95)
            r.command = CMD_FIND;
        else
            r.command = CMD_NONE;
        if (r.command != CMD_INSERT && $urandom_range(0, 9) == 0)
            r.entry_id = $urandom;
        return r;
    endfunction

    initial
    begin
        int i;
        int j;
        int sent;
        int burst;
        int waited;
        bit filling;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // empty queue
        issue(make_lookup(CMD_FIND, 32'd5));
        issue(make_lookup(CMD_REMOVE, 32'd5));
        issue(make_lookup(CMD_NONE, 32'd5));

        // date, rank, undated and id tie breaks, immediate and priority extremes
        issue(make_insert(32'd10, 1'b0, 6'd20, 32'd1000, 1'b1, 16'd5));
        issue(make_insert(32'd11, 1'b0, 6'd20, 32'd500, 1'b0, 16'd9));
        issue(make_insert(32'd12, 1'b0, 6'd20, 32'd1000, 1'b1, 16'd3));
        issue(make_insert(32'd13, 1'b0, 6'd20, 32'd0, 1'b0, 16'd0));
        issue(make_insert(32'd9, 1'b0, 6'd20, 32'd0, 1'b0, 16'd0));
        issue(make_insert(32'h0, 1'b0, 6'd0, 32'hFFFF_FFFF, 1'b1, 16'hFFFF));
        issue(make_insert(32'hFFFF_FFFF, 1'b0, 6'd39, 32'd0, 1'b0, 16'd0));
        issue(make_insert(32'd20, 1'b1, 6'd39, 32'd2000, 1'b0, 16'd0));
        issue(make_insert(32'd21, 1'b1, 6'd0, 32'd1000, 1'b1, 16'd1));
        issue(make_insert(32'd10, 1'b0, 6'd20, 32'd1000, 1'b1, 16'd5));
        issue(make_insert(32'd22, 1'b0, 6'd5, 32'd1, 1'b1, 16'd0));
        for (i = 0; i < 5; i++)
            issue(make_insert(32'(23 + i), 1'($urandom), 6'($urandom_range(0, 39)),
                              $urandom, 1'($urandom), 16'($urandom)));
        // queue is full now
        issue(make_insert(32'd30, 1'b1, 6'd0, 32'd1, 1'b1, 16'd0));

        issue(make_lookup(CMD_FIND, 32'd10));
        issue(make_lookup(CMD_FIND, 32'd99));
        issue(make_lookup(CMD_REMOVE, 32'd21));
        issue(make_lookup(CMD_REMOVE, 32'd10));
        issue(make_lookup(CMD_REMOVE, 32'd99));
        issue(make_lookup(CMD_NONE, 32'd12));
        pause($urandom_range(1, 4));

        sent = 0;
        filling = 1'b1;
        while (sent < 500)
        begin
            burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
            for (j = 0; j < burst && sent < 500; j++)
            begin
                if (sent % 40 == 39)
                    filling = !filling;
                issue(random_request(filling));
                sent++;
            end
            pause(($urandom_range(0, 9) == 0) ? 25 : $urandom_range(1, 5));
        end

        waited = 0;
        while (outstanding != 0 && waited < 200)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (4) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/prq_pkg.sv
rtl/prq_cell.sv
rtl/print_request_priority_queue.sv
sim/queue_order_checker.sv
sim/tb_top.sv
